// ===== sv/txsq_pkg.sv =====
// Shared types and constants for the TXSQ message framer.
package txsq_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam int ADDR_W = 24;
    localparam int LEN_W  = 8;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 5;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_ERROR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic                close;
        logic [BYTE_W-1:0]   data;
    } t_cmd;

endpackage

// ===== sv/txsq_front.sv =====
// Front end: accepts requests, tracks the open frame and issues commands.
module txsq_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_op,
    input  logic [txsq_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [txsq_pkg::LEN_W-1:0]  i_payload_len,
    output txsq_pkg::t_cmd              o_cmd,
    output logic                        o_frame_open
);
    import txsq_pkg::*;

    logic             r_frame_open;
    logic             n_frame_open;
    logic [LEN_W-1:0] r_bytes_sent;
    logic [LEN_W-1:0] n_bytes_sent;
    logic [LEN_W-1:0] w_count;

    assign w_count = r_bytes_sent + LEN_W'(1);

    always_comb begin
        n_frame_open = r_frame_open;
        n_bytes_sent = r_bytes_sent;
        o_cmd.kind   = CMD_ERROR;
        o_cmd.close  = 1'b1;
        o_cmd.data   = i_data_byte;
        if (!i_op) begin
            o_cmd.kind   = CMD_START;
            o_cmd.close  = (i_payload_len == '0);
            n_frame_open = (i_payload_len != '0);
            n_bytes_sent = '0;
        end else if (r_frame_open) begin
            o_cmd.kind  = CMD_DATA;
            o_cmd.close = (w_count >= i_payload_len);
            if (w_count >= i_payload_len) begin
                n_frame_open = 1'b0;
                n_bytes_sent = '0;
            end else begin
                n_bytes_sent = w_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_bytes_sent <= '0;
        end else if (i_accept) begin
            r_frame_open <= n_frame_open;
            r_bytes_sent <= n_bytes_sent;
        end
    end

    assign o_frame_open = r_frame_open;

endmodule

// ===== sv/txsq_cmd_queue.sv =====
// Small command queue between the front end and the byte emitter.
module txsq_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  txsq_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output txsq_pkg::t_cmd o_cmd,
    output logic           o_valid,
    output logic           o_full
);
    import txsq_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   w_push;
    logic                   w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/txsq_back.sv =====
// Back end: expands commands into frame bytes and keeps the running checksum.
module txsq_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  txsq_pkg::t_cmd              i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_pop,
    input  logic [txsq_pkg::ADDR_W-1:0] i_local_addr,
    input  logic [txsq_pkg::ADDR_W-1:0] i_dest_addr,
    input  logic [txsq_pkg::LEN_W-1:0]  i_payload_len,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [txsq_pkg::BYTE_W-1:0] o_frame_byte,
    output logic                        o_last,
    output logic                        o_error
);
    import txsq_pkg::*;

    localparam logic [BYTE_W-1:0] CATEGORY  = 8'h46;
    localparam logic [BYTE_W-1:0] HDR_PAD   = 8'h00;
    localparam logic [BYTE_W-1:0] HDR_TAIL  = 8'hA4;
    localparam logic [LEN_W:0]    LEN_EXTRA = 9'd19;
    localparam logic [IDX_W-1:0]  HDR_LEN   = 5'd18;
    localparam logic [IDX_W-1:0]  HDR_END   = 5'd17;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_frame_byte;
    logic              r_last;
    logic              r_error;
    logic [IDX_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_xor;

    logic              w_advance;
    logic              w_emit;
    logic              w_is_ck;
    logic              w_done;
    logic [BYTE_W-1:0] w_hdr_byte;
    logic [BYTE_W-1:0] w_byte;
    logic [BYTE_W-1:0] n_xor;
    logic [LEN_W:0]    w_total;
    logic [LEN_W+3:0]  w_bits;

    assign w_total = {1'b0, i_payload_len} + LEN_EXTRA;
    assign w_bits  = {({1'b0, i_payload_len} + 9'd1), 3'b000};

    always_comb begin
        case (r_idx)
            5'd0:    w_hdr_byte = 8'h24;
            5'd1:    w_hdr_byte = 8'h54;
            5'd2:    w_hdr_byte = 8'h58;
            5'd3:    w_hdr_byte = 8'h53;
            5'd4:    w_hdr_byte = 8'h51;
            5'd5:    w_hdr_byte = {7'd0, w_total[LEN_W]};
            5'd6:    w_hdr_byte = w_total[7:0];
            5'd7:    w_hdr_byte = i_local_addr[23:16];
            5'd8:    w_hdr_byte = i_local_addr[15:8];
            5'd9:    w_hdr_byte = i_local_addr[7:0];
            5'd10:   w_hdr_byte = CATEGORY;
            5'd11:   w_hdr_byte = i_dest_addr[23:16];
            5'd12:   w_hdr_byte = i_dest_addr[15:8];
            5'd13:   w_hdr_byte = i_dest_addr[7:0];
            5'd14:   w_hdr_byte = {4'd0, w_bits[11:8]};
            5'd15:   w_hdr_byte = w_bits[7:0];
            5'd16:   w_hdr_byte = HDR_PAD;
            5'd17:   w_hdr_byte = HDR_TAIL;
            default: w_hdr_byte = HDR_PAD;
        endcase
    end

    always_comb begin
        w_is_ck = 1'b0;
        w_done  = 1'b1;
        w_byte  = '0;
        n_xor   = r_xor;
        case (i_cmd.kind)
            CMD_START: begin
                w_is_ck = (r_idx == HDR_LEN);
                w_done  = w_is_ck || ((r_idx == HDR_END) && !i_cmd.close);
                w_byte  = w_hdr_byte;
                n_xor   = (r_idx == '0) ? w_hdr_byte : (r_xor ^ w_hdr_byte);
            end
            CMD_DATA: begin
                w_is_ck = (r_idx != '0);
                w_done  = w_is_ck || !i_cmd.close;
                w_byte  = i_cmd.data;
                n_xor   = r_xor ^ i_cmd.data;
            end
            default: begin
                w_is_ck = 1'b0;
                w_done  = 1'b1;
                w_byte  = '0;
                n_xor   = r_xor;
            end
        endcase
        if (w_is_ck) begin
            w_byte = r_xor;
            n_xor  = '0;
        end
    end

    assign w_advance = !r_out_valid || !i_out_stall;
    assign w_emit    = w_advance && i_cmd_valid;
    assign o_cmd_pop = w_emit && w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_xor       <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= i_cmd_valid;
            end
            if (w_emit) begin
                r_idx <= w_done ? '0 : (r_idx + IDX_W'(1));
                r_xor <= n_xor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_frame_byte <= w_byte;
            r_last       <= w_is_ck || (i_cmd.kind == CMD_ERROR);
            r_error      <= (i_cmd.kind == CMD_ERROR);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_frame_byte;
    assign o_last       = r_last;
    assign o_error      = r_error;

endmodule

// ===== sv/txsq_message_framer.sv =====
// Top level of the TXSQ message framer: configuration registers and wiring.
// A payload request passes through the command queue and the output register; one byte leaves per cycle unless stalled.
// A start request yields 18 header bytes (19 with zero length) from the byte emitter, one a cycle unless stalled.
// A payload byte that closes the frame is followed by the checksum byte; all others give one byte.
// A four-entry command queue lets requests keep arriving while the emitter works through headers.
// Synchronous active-low reset clears the frame state, the queue and the output valid.
module txsq_message_framer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [txsq_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [txsq_pkg::BYTE_W-1:0] i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [txsq_pkg::BYTE_W-1:0] o_frame_byte,
    output logic                        o_last,
    output logic                        o_error
);
    import txsq_pkg::*;

    localparam logic [1:0]        REG_LOCAL_ADDR = 2'd0;
    localparam logic [1:0]        REG_DEST_ADDR  = 2'd1;
    localparam logic [1:0]        REG_PAYLOAD    = 2'd2;
    localparam logic [ADDR_W-1:0] LOCAL_RESET    = 24'h04E3C8;

    logic [ADDR_W-1:0] r_local_addr;
    logic [ADDR_W-1:0] r_dest_addr;
    logic [LEN_W-1:0]  r_payload_len;

    logic w_in_accept;
    logic w_full;
    logic w_cmd_valid;
    logic w_cmd_pop;
    logic w_frame_open;
    t_cmd w_front_cmd;
    t_cmd w_head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr  <= LOCAL_RESET;
            r_dest_addr   <= '0;
            r_payload_len <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LOCAL_ADDR: r_local_addr  <= i_cfg_data;
                REG_DEST_ADDR:  r_dest_addr   <= i_cfg_data;
                REG_PAYLOAD:    r_payload_len <= i_cfg_data[LEN_W-1:0];
                default:        r_payload_len <= r_payload_len;
            endcase
        end
    end

    assign o_in_stall  = w_full;
    assign w_in_accept = i_in_valid && !w_full;

    txsq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .i_payload_len (r_payload_len),
        .o_cmd         (w_front_cmd),
        .o_frame_open  (w_frame_open)
    );

    txsq_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_accept),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_head_cmd),
        .o_valid (w_cmd_valid),
        .o_full  (w_full)
    );

    txsq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_head_cmd),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_pop     (w_cmd_pop),
        .i_local_addr  (r_local_addr),
        .i_dest_addr   (r_dest_addr),
        .i_payload_len (r_payload_len),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_frame_byte  (o_frame_byte),
        .o_last        (o_last),
        .o_error       (o_error)
    );

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_last && (o_frame_byte == '0)))
        else $error("Error result must be a zero byte marked last.");

    a_zero_len_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && !i_op && (r_payload_len == '0)) |=> !w_frame_open)
        else $error("A zero-length start request must leave no frame open.");

    a_emitter_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && w_cmd_valid) |=> o_out_valid)
        else $error("A queued command must reach an empty output register.");

endmodule
